// ===== design/upn_pkg.sv =====
// Shared types, constants and byte-class helpers for the URI percent normalizer.
// No dependencies; used by every module of the block.
package upn_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam int unsigned MAX_OUT = 5;
	localparam int unsigned CNT_W = 3;

	localparam logic [7:0] PCT = 8'h25;
	localparam logic [7:0] HEX_CASE_MASK = 8'h4F;

	// configuration register indexes
	localparam logic [1:0] CFG_EXTRA_A = 2'd0;
	localparam logic [1:0] CFG_EXTRA_B = 2'd1;
	localparam logic [1:0] CFG_EXTRA_C = 2'd2;
	localparam logic [1:0] CFG_EXTRA_D = 2'd3;

	// held escape state
	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_PCT = 2'd1;
	localparam logic [1:0] HELD_DIGIT = 2'd2;

	// one accepted byte worth of output, bytes[0] goes first
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;
		logic [CNT_W-1:0] count;
		logic last;
	} upn_cmd_t;

	function automatic logic is_hex(input logic [7:0] b);
		return (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] b);
		logic [7:0] t;
		t = (b & HEX_CASE_MASK) - 8'h41 + 8'd10;
		if (b <= 8'h39)
			return 4'(b - 8'h30);
		return t[3:0];
	endfunction

	function automatic logic is_unreserved(input logic [7:0] c);
		return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
			8'h2D, 8'h2E, 8'h5F, 8'h7E});
	endfunction

	function automatic logic is_printable(input logic [7:0] c);
		return (c inside {[8'h21:8'h7E]});
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		if (v < 4'd10)
			return 8'h30 + {4'd0, v};
		return 8'h41 + {4'd0, v} - 8'd10;
	endfunction

endpackage

// ===== design/upn_front.sv =====
// Front end: config registers, escape state tracking and byte classification.
// Turns each accepted input byte into at most one output command, none if it gives no output. Uses upn_pkg.
module upn_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data,
	input  logic             accept,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	output logic             push,
	output upn_pkg::upn_cmd_t cmd
);
	import upn_pkg::*;

	logic [3:0][7:0] extra_q;
	logic [1:0] held_q;
	logic [7:0] h1_q;

	logic [1:0] held_nxt;
	logic [7:0] h1_nxt;
	logic [MAX_OUT-1:0][7:0] obuf;
	logic [CNT_W-1:0] n;
	logic feed;
	logic [7:0] dec;

	function automatic logic is_extra(input logic [7:0] c, input logic [3:0][7:0] ex);
		return (c != 8'd0) && (c == ex[0] || c == ex[1] || c == ex[2] || c == ex[3]);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extra_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_EXTRA_A: extra_q[0] <= cfg_data;
				CFG_EXTRA_B: extra_q[1] <= cfg_data;
				CFG_EXTRA_C: extra_q[2] <= cfg_data;
				CFG_EXTRA_D: extra_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		obuf = '0;
		n = '0;
		held_nxt = held_q;
		h1_nxt = h1_q;
		feed = 1'b0;
		dec = {hex_val(h1_q), hex_val(in_byte)};

		case (held_q)
			HELD_NONE: begin
				feed = 1'b1;
			end
			HELD_PCT: begin
				if (is_hex(in_byte)) begin
					held_nxt = HELD_DIGIT;
					h1_nxt = in_byte;
				end else begin
					held_nxt = HELD_NONE;
					obuf[n] = PCT; n = n + 1'b1;
					feed = 1'b1;
				end
			end
			default: begin
				held_nxt = HELD_NONE;
				if (is_hex(in_byte)) begin
					if (dec != 8'd0 && (is_unreserved(dec) || is_extra(dec, extra_q))) begin
						obuf[n] = dec; n = n + 1'b1;
					end else begin
						obuf[n] = PCT; n = n + 1'b1;
						obuf[n] = h1_q; n = n + 1'b1;
						obuf[n] = in_byte; n = n + 1'b1;
					end
				end else begin
					obuf[n] = PCT; n = n + 1'b1;
					obuf[n] = h1_q; n = n + 1'b1;
					feed = 1'b1;
				end
			end
		endcase

		if (feed) begin
			if (in_byte == PCT) begin
				held_nxt = HELD_PCT;
			end else if (is_printable(in_byte) || is_extra(in_byte, extra_q)) begin
				obuf[n] = in_byte; n = n + 1'b1;
			end else begin
				obuf[n] = PCT; n = n + 1'b1;
				obuf[n] = hex_digit(in_byte[7:4]); n = n + 1'b1;
				obuf[n] = hex_digit(in_byte[3:0]); n = n + 1'b1;
			end
		end

		// flush a pending escape at the end of the part
		if (in_last) begin
			if (held_nxt != HELD_NONE) begin
				obuf[n] = PCT; n = n + 1'b1;
			end
			if (held_nxt == HELD_DIGIT) begin
				obuf[n] = h1_nxt; n = n + 1'b1;
			end
			held_nxt = HELD_NONE;
		end
	end

	assign cmd.bytes = obuf;
	assign cmd.count = n;
	assign cmd.last = in_last;
	assign push = accept && (n != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= HELD_NONE;
			h1_q <= '0;
		end else if (accept) begin
			held_q <= held_nxt;
			h1_q <= h1_nxt;
		end
	end

endmodule

// ===== design/upn_queue.sv =====
// Small command queue between front and back ends.
// Register-based FIFO of upn_cmd_t entries. Uses upn_pkg.
module upn_queue #(
	parameter int unsigned DEPTH = upn_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  upn_pkg::upn_cmd_t wr_data,
	output logic              full,
	input  logic              pop,
	output upn_pkg::upn_cmd_t rd_data,
	output logic              empty
);
	import upn_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

	upn_cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic do_push, do_pop;

	assign full = (fill_q == FILL_MAX);
	assign empty = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

// ===== design/upn_back.sv =====
// Back end: holds one command and sends its bytes out one beat at a time.
// Loads the next command from the queue as the current one finishes. Uses upn_pkg.
module upn_back (
	input  logic              clk,
	input  logic              arst_n,
	input  upn_pkg::upn_cmd_t q_data,
	input  logic              q_empty,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_last
);
	import upn_pkg::*;

	upn_cmd_t cur_q;
	logic [CNT_W-1:0] idx_q;
	logic busy_q;
	logic on_final, finishing;

	assign on_final = (idx_q == cur_q.count - 1'b1);
	assign finishing = busy_q && out_ready && on_final;
	assign q_pop = (!busy_q || finishing) && !q_empty;

	assign out_valid = busy_q;
	assign out_byte = cur_q.bytes[idx_q];
	assign out_last = cur_q.last && on_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (finishing) begin
			busy_q <= 1'b0;
		end else if (busy_q && out_ready) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_data;
	end

endmodule

// ===== design/uri_percent_normalizer_unit.sv =====
// Top level of the URI percent normalizer: front end, command queue, back end.
// Depends on upn_pkg, upn_front, upn_queue, upn_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------
//  in       | in_valid / in_ready  | in_byte[7:0], in_last
//  out      | out_valid / out_ready| out_byte[7:0], out_last
//  cfg      | cfg_wr_en            | cfg_index[1:0], cfg_data[7:0]
//
// One input beat per cycle while the queue has room; the front end decides in the
// accept cycle. The back end sends one output byte per cycle while out_ready is
// high; a byte that expands to N output bytes takes N beats, and the queue
// (QUEUE_DEPTH commands) absorbs short bursts. Output goes via the queue and
// back end register. Reset clears config, escape state, queue; no clearing pass.
module uri_percent_normalizer_unit #(
	parameter int unsigned QUEUE_DEPTH = upn_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import upn_pkg::*;

	upn_cmd_t wr_cmd, rd_cmd;
	logic push, full, pop, empty;

	assign in_ready = !full;

	upn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (in_valid && in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.push     (push),
		.cmd      (wr_cmd)
	);

	upn_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(wr_cmd),
		.full   (full),
		.pop    (pop),
		.rd_data(rd_cmd),
		.empty  (empty)
	);

	upn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_data   (rd_cmd),
		.q_empty  (empty),
		.q_pop    (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.out_last (out_last)
	);

endmodule

// ===== verif/uri_percent_normalizer_unit_tb.sv =====
// Self-checking testbench for uri_percent_normalizer_unit: directed and random byte streams of URI parts,
// with a scoreboard class that predicts the normalized output beats.
// Depends on upn_pkg and the RTL of the block; nothing else.
module uri_percent_normalizer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import upn_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 64;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 32;

	typedef struct {
		logic [7:0] data;
		logic last;
	} norm_beat_t;

	// Predicts the normalized bytes of each input beat and checks the output against them.
	class norm_scoreboard;
		logic [7:0] extra [4];
		logic [1:0] held;
		logic [7:0] held_digit;
		logic [7:0] step_out [$];
		norm_beat_t pending_bytes [$];
		int n_in;
		int n_out;
		int n_err;

		function new();
			foreach (extra[i])
				extra[i] = 8'h00;
			held = HELD_NONE;
			held_digit = 8'h00;
			n_in = 0;
			n_out = 0;
			n_err = 0;
		endfunction

		function void set_extra(logic [1:0] idx, logic [7:0] v);
			extra[idx] = v;
		endfunction

		function int pending();
			return pending_bytes.size();
		endfunction

		function bit is_kept(logic [7:0] b);
			return b != 8'h00 && (b == extra[0] || b == extra[1] || b == extra[2] ||
				b == extra[3]);
		endfunction

		function bit is_hexch(logic [7:0] b);
			return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
				(b >= 8'h61 && b <= 8'h66);
		endfunction

		// letters of either case have 1..6 in the low nibble
		function logic [3:0] nibble(logic [7:0] b);
			if (b <= 8'h39)
				return b[3:0];
			return b[3:0] + 4'd9;
		endfunction

		function bit unreserved(logic [7:0] c);
			return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
				(c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h2E ||
				c == 8'h5F || c == 8'h7E;
		endfunction

		function logic [7:0] upper_hex(logic [3:0] v);
			if (v < 4'd10)
				return 8'h30 + v;
			return 8'h37 + v;
		endfunction

		// byte seen outside an escape
		function void plain_byte(logic [7:0] b);
			if (b == PCT) begin
				held = HELD_PCT;
			end else if ((b >= 8'h21 && b <= 8'h7E) || is_kept(b)) begin
				step_out.push_back(b);
			end else begin
				step_out.push_back(PCT);
				step_out.push_back(upper_hex(b[7:4]));
				step_out.push_back(upper_hex(b[3:0]));
			end
		endfunction

		function void note_input(logic [7:0] b, logic last);
			logic [7:0] c;
			norm_beat_t e;
			step_out.delete();
			n_in++;
			case (held)
				HELD_NONE: begin
					plain_byte(b);
				end
				HELD_PCT: begin
					if (is_hexch(b)) begin
						held_digit = b;
						held = HELD_DIGIT;
					end else begin
						held = HELD_NONE;
						step_out.push_back(PCT);
						plain_byte(b);
					end
				end
				default: begin
					held = HELD_NONE;
					if (is_hexch(b)) begin
						c = {nibble(held_digit), nibble(b)};
						if (c != 8'h00 && (unreserved(c) || is_kept(c))) begin
							step_out.push_back(c);
						end else begin
							step_out.push_back(PCT);
							step_out.push_back(held_digit);
							step_out.push_back(b);
						end
					end else begin
						step_out.push_back(PCT);
						step_out.push_back(held_digit);
						plain_byte(b);
					end
				end
			endcase
			// end of part flushes an unfinished escape as is
			if (last) begin
				if (held != HELD_NONE)
					step_out.push_back(PCT);
				if (held == HELD_DIGIT)
					step_out.push_back(held_digit);
				held = HELD_NONE;
			end
			foreach (step_out[i]) begin
				e.data = step_out[i];
				e.last = last && (i == step_out.size() - 1);
				pending_bytes.push_back(e);
			end
		endfunction

		task report(string what);
			$display("MISMATCH at output beat %0d: %s", n_out, what);
			n_err++;
		endtask

		task check_out_beat(logic [7:0] b, logic last);
			norm_beat_t e;
			n_out++;
			if (pending_bytes.size() == 0) begin
				report($sformatf("unexpected beat byte=%02h last=%0b", b, last));
				return;
			end
			e = pending_bytes.pop_front();
			if (b !== e.data)
				report($sformatf("out_byte %02h, expected %02h", b, e.data));
			if (last !== e.last)
				report($sformatf("out_last %0b, expected %0b", last, e.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = CFG_EXTRA_A;
	logic [7:0] cfg_data = 8'h00;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] in_byte = 8'h41;
	logic in_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_byte;
	logic out_last;

	norm_scoreboard sb = new();
	int cycles = 0;
	int items_sent = 0;
	int settings_done = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	logic [7:0] cur_extra [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
	logic [7:0] tok [$];
	logic [7:0] phase_cfg [PHASES][4] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h2F, 8'h3A, 8'h40, 8'h20},
		'{8'h25, 8'h01, 8'h7F, 8'hFF},
		'{8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h80, 8'hFF, 8'h00, 8'h3F},
		'{8'h00, 8'h00, 8'h00, 8'h00}
	};

	uri_percent_normalizer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.out_last(out_last)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still expected", cycles, sb.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// scoreboard taps
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				sb.set_extra(cfg_index, cfg_data);
			if (out_valid && out_ready)
				sb.check_out_beat(out_byte, out_last);
			if (in_valid && in_ready)
				sb.note_input(in_byte, in_last);
		end
	end

	// output side: random stall bursts, or one long hold when asked
	initial begin
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task send_beat(logic [7:0] b, logic last);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= last;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	task send_part(string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], i == s.len() - 1);
	endtask

	// pause the input until every expected beat is out, then let the pipe settle
	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task cfg_write(logic [1:0] idx, logic [7:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		cur_extra[idx] = v;
		@(posedge clk);
	endtask

	task write_extras(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
		cfg_write(CFG_EXTRA_A, a);
		cfg_write(CFG_EXTRA_B, b);
		cfg_write(CFG_EXTRA_C, c);
		cfg_write(CFG_EXTRA_D, d);
		cfg_wr_en <= 1'b0;
		settings_done++;
	endtask

	function logic [7:0] hex_char(logic [3:0] v, bit lower);
		if (v < 4'd10)
			return 8'h30 + v;
		return (lower ? 8'h57 : 8'h37) + v;
	endfunction

	function logic [7:0] non_hex();
		logic [7:0] x;
		do
			x = 8'($urandom_range(1, 255));
		while ((x >= 8'h30 && x <= 8'h39) || (x >= 8'h41 && x <= 8'h46) ||
			(x >= 8'h61 && x <= 8'h66));
		return x;
	endfunction

	// one lexical piece of a URI part: escape, broken escape, or a single byte
	function void fill_token();
		int sel;
		logic [7:0] c;
		sel = $urandom_range(0, 99);
		tok.delete();
		if (sel < 35) begin
			case ($urandom_range(0, 3))
				0: c = cur_extra[$urandom_range(0, 3)];
				1: c = 8'($urandom_range(8'h41, 8'h5A));
				default: c = 8'($urandom_range(0, 255));
			endcase
			tok.push_back(PCT);
			tok.push_back(hex_char(c[7:4], 1'($urandom_range(0, 1))));
			tok.push_back(hex_char(c[3:0], 1'($urandom_range(0, 1))));
		end else if (sel < 45) begin
			tok.push_back(PCT);
			if ($urandom_range(0, 1))
				tok.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
			tok.push_back(non_hex());
		end else if (sel < 50) begin
			tok.push_back(PCT);
		end else if (sel < 75) begin
			tok.push_back(8'($urandom_range(8'h21, 8'h7E)));
		end else if (sel < 88) begin
			if ($urandom_range(0, 1))
				tok.push_back(8'($urandom_range(8'h01, 8'h20)));
			else
				tok.push_back(8'($urandom_range(8'h7F, 8'hFF)));
		end else begin
			c = cur_extra[$urandom_range(0, 3)];
			tok.push_back(c == 8'h00 ? 8'h7E : c);
		end
	endfunction

	task send_random_part();
		int n_tok;
		n_tok = $urandom_range(1, 8);
		for (int t = 0; t < n_tok; t++) begin
			fill_token();
			foreach (tok[i])
				send_beat(tok[i], t == n_tok - 1 && i == tok.size() - 1);
		end
	endtask

	initial begin : stim
		int target;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < PHASES; p++) begin
			if (p == 3 || p == 5) begin
				for (int r = 0; r < 4; r++)
					phase_cfg[p][r] = 8'($urandom_range(0, 255));
			end
			drain();
			write_extras(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
			calm = (p == 3 || p == 5);
			if (p == 0) begin
				// decode, pass-through, zero escape, broken and flushed escapes, encoding
				send_part("%41%7e%2F%00");
				send_part("%G1%4");
				send_beat(8'h00, 1'b0);
				send_beat(8'hFF, 1'b0);
				send_beat(8'h20, 1'b0);
				send_beat(8'h7F, 1'b0);
				send_part("!~%");
				send_part("%%41");
			end
			if (p == 1) begin
				// sink holds off while beats keep coming, so the queue backs up
				calm = 1'b1;
				hold_req = 1'b1;
				target = items_sent + 20;
				while (items_sent < target)
					send_random_part();
				calm = 1'b0;
			end
			target = items_sent + ITEMS_PER_PHASE;
			while (items_sent < target)
				send_random_part();
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("covered %0d input beats in %0d register settings, %0d output beats checked",
			sb.n_in, settings_done, sb.n_out);
		if (sb.n_err == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
design/upn_pkg.sv
design/upn_front.sv
design/upn_queue.sv
design/upn_back.sv
design/uri_percent_normalizer_unit.sv
verif/uri_percent_normalizer_unit_tb.sv
